// File: sv/pes_pkg.sv
// Shared types and constants for the periodic event scheduler.
package pes_pkg;
	localparam int MaxTasksDefault = 64;

	typedef enum logic [1:0] {
		MODE_REG   = 2'd0,
		MODE_NEXT  = 2'd1,
		MODE_CLEAR = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_EMIT  = 2'd0,
		ST_OK    = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [15:0] task_id;
		logic [15:0] task_period;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] due_id;
		logic [31:0] due_time;
	} rsp_t;
endpackage

// File: sv/pes_if.sv
// Valid/ready channel interfaces for requests and results.
interface pes_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [15:0] task_id;
	logic [15:0] task_period;
	modport source (output valid, mode, task_id, task_period, input ready);
	modport sink (input valid, mode, task_id, task_period, output ready);
endinterface

interface pes_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [15:0] due_id;
	logic [31:0] due_time;
	modport source (output valid, status, due_id, due_time, input ready);
	modport sink (input valid, status, due_id, due_time, output ready);
endinterface

// File: sv/periodic_event_scheduler_unit.sv
// Periodic event scheduler: request queue front end and task table back end.
// Usage:
//  - req channel carries mode, task_id and task_period; rsp channel returns
//    status, due_id and due_time, exactly one result per request.
//  - mode 0 registers a task (first due time = period), mode 1 takes the
//    task with smallest due time (lower id on a tie) and advances it by its
//    period with saturation, mode 2 empties the table.
//  - Register, clear and status-only requests are answered from the result register without a table scan.
//  - A take request scans the table one entry a cycle through the single
//    memory read port.
//  - A two-entry queue keeps accepting requests while a result waits.
//  - Reset empties the table and the queue; table contents need no clearing.
//  - When the receiver stalls, the result holds and the back end waits.
module periodic_event_scheduler_unit #(
	parameter int MAX_TASKS = pes_pkg::MaxTasksDefault
) (
	input logic       clk,
	input logic       arst_n,
	pes_req_if.sink   req,
	pes_rsp_if.source rsp
);
	import pes_pkg::*;

	req_t q_data;
	logic q_valid, q_pop;

	pes_front u_front (
		.clk(clk), .arst_n(arst_n), .req(req),
		.q_data(q_data), .q_valid(q_valid), .q_pop(q_pop)
	);

	pes_back #(.MAX_TASKS(MAX_TASKS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_data(q_data), .q_valid(q_valid), .q_pop(q_pop), .rsp(rsp)
	);
endmodule

// File: sv/pes_front.sv
// Request intake and two-entry request queue.
module pes_front (
	input  logic          clk,
	input  logic          arst_n,
	pes_req_if.sink       req,
	output pes_pkg::req_t q_data,
	output logic          q_valid,
	input  logic          q_pop
);
	import pes_pkg::*;

	req_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push;

	assign req.ready = (cnt_q != 2'd2);
	assign push      = req.valid && req.ready;
	assign q_valid   = (cnt_q != 2'd0);
	assign q_data    = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= '{mode: req.mode, task_id: req.task_id,
				task_period: req.task_period};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop && q_valid) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop && q_valid);
		end
	end
endmodule

// File: sv/pes_back.sv
// Task table with a sequential minimum scan and result register.
module pes_back #(
	parameter int MAX_TASKS = pes_pkg::MaxTasksDefault
) (
	input  logic          clk,
	input  logic          arst_n,
	input  pes_pkg::req_t q_data,
	input  logic          q_valid,
	output logic          q_pop,
	pes_rsp_if.source     rsp
);
	import pes_pkg::*;

	localparam int AW = $clog2(MAX_TASKS);
	localparam int CW = $clog2(MAX_TASKS + 1);

	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_LAST, S_UPD, S_OUT} state_t;

	logic [15:0] id_mem [MAX_TASKS];
	logic [15:0] per_mem [MAX_TASKS];
	logic [31:0] due_mem [MAX_TASKS];

	state_t      state_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [AW-1:0] best_q;
	logic [15:0] best_id_q, best_per_q, rd_id_q, rd_per_q;
	logic [31:0] best_due_q, rd_due_q;
	logic        first_q;
	rsp_t        out_q;
	logic        wr_en;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [15:0] wr_id, wr_per;
	logic [31:0] wr_due;
	logic        better;
	logic [32:0] sum;

	assign rsp.valid    = (state_q == S_OUT);
	assign rsp.status   = out_q.status;
	assign rsp.due_id   = out_q.due_id;
	assign rsp.due_time = out_q.due_time;
	assign q_pop        = (state_q == S_IDLE) && q_valid;

	assign rd_addr = idx_q[AW-1:0];
	assign better  = first_q || (rd_due_q < best_due_q) ||
		(rd_due_q == best_due_q && rd_id_q < best_id_q);
	assign sum     = {1'b0, best_due_q} + {17'd0, best_per_q};

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = best_q;
		wr_id   = best_id_q;
		wr_per  = best_per_q;
		wr_due  = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
		if (state_q == S_IDLE && q_valid && mode_t'(q_data.mode) == MODE_REG
			&& count_q < CW'(MAX_TASKS)) begin
			wr_en   = 1'b1;
			wr_addr = count_q[AW-1:0];
			wr_id   = q_data.task_id;
			wr_per  = q_data.task_period;
			wr_due  = {16'd0, q_data.task_period};
		end else if (state_q == S_UPD) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			id_mem[wr_addr]  <= wr_id;
			per_mem[wr_addr] <= wr_per;
			due_mem[wr_addr] <= wr_due;
		end
		rd_id_q  <= id_mem[rd_addr];
		rd_per_q <= per_mem[rd_addr];
		rd_due_q <= due_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			best_q  <= '0;
			first_q <= 1'b0;
			out_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						unique case (mode_t'(q_data.mode))
							MODE_REG: begin
								state_q <= S_OUT;
								if (count_q < CW'(MAX_TASKS)) begin
									count_q <= count_q + 1'b1;
									out_q   <= '{status: ST_OK, due_id: 16'd0,
										due_time: 32'd0};
								end else begin
									out_q <= '{status: ST_FULL, due_id: 16'd0,
										due_time: 32'd0};
								end
							end
							MODE_NEXT: begin
								if (count_q == '0) begin
									out_q   <= '{status: ST_EMPTY, due_id: 16'd0,
										due_time: 32'd0};
									state_q <= S_OUT;
								end else begin
									idx_q   <= '0;
									first_q <= 1'b1;
									state_q <= S_SCAN;
								end
							end
							MODE_CLEAR: begin
								count_q <= '0;
								out_q   <= '{status: ST_OK, due_id: 16'd0, due_time: 32'd0};
								state_q <= S_OUT;
							end
							default: begin
								out_q   <= '{status: ST_OK, due_id: 16'd0, due_time: 32'd0};
								state_q <= S_OUT;
							end
						endcase
					end
				end
				S_SCAN: begin
					// Read of idx_q issued; advance address.
					idx_q   <= idx_q + 1'b1;
					state_q <= S_LAST;
				end
				S_LAST: begin
					if (better) begin
						best_q     <= AW'(idx_q - 1'b1);
						best_id_q  <= rd_id_q;
						best_per_q <= rd_per_q;
						best_due_q <= rd_due_q;
					end
					first_q <= 1'b0;
					if (idx_q == count_q) state_q <= S_UPD;
					else idx_q <= idx_q + 1'b1;
				end
				S_UPD: begin
					out_q   <= '{status: ST_EMIT, due_id: best_id_q, due_time: best_due_q};
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (rsp.ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
